>>> rtl/core/mfre_pkg.sv
// Package for the monochrome framebuffer raster engine.
// Holds sizes, opcodes, controller states and the command/status structs.
// No dependencies.
`default_nettype none
package mfre_pkg;
	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 64;
	localparam int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8;
	localparam int STORE_BYTES   = ROW_BYTES * SCREEN_HEIGHT;
	localparam int ADDR_W        = $clog2(STORE_BYTES);
	localparam int COL_W         = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
	localparam int ROW_W         = $clog2(SCREEN_HEIGHT);

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_SPRITE = 3'd1;
	localparam logic [2:0] OP_SPAN   = 3'd2;
	localparam logic [2:0] OP_RECT   = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	typedef enum logic [2:0] {
		ST_INIT, ST_IDLE, ST_CLEAR, ST_WALK, ST_RMW, ST_READ, ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request and set up walk
		logic clr_wr;    // write zero at walk address
		logic rd;        // read byte at walk address
		logic wr;        // write modified byte back
		logic step;      // advance walk
		logic rd_out;    // read for read request
		logic out_load;  // load result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;     // nothing to draw
		logic last;      // walk at final position
		logic skip;      // current position draws nothing
	} stat_t;
endpackage
`default_nettype wire

>>> rtl/core/mfre_datapath.sv
// Datapath: request registers, walk counters, mask generation, frame store.
// Depends on mfre_pkg.
`default_nettype none
module mfre_datapath (
	input  wire                clk,
	input  wire                arst_n,
	input  wire mfre_pkg::cmd_t cmd,
	output mfre_pkg::stat_t    stat,
	input  wire  [2:0]         opcode,
	input  wire  signed [9:0]  x_left,
	input  wire  signed [9:0]  y_top,
	input  wire  signed [9:0]  x_right,
	input  wire  signed [9:0]  y_bottom,
	input  wire  [63:0]        sprite_rows,
	input  wire  [9:0]         read_address,
	output logic [7:0]         read_data,
	output logic [2:0]         done_opcode
);
	localparam int W = mfre_pkg::SCREEN_WIDTH;
	localparam int H = mfre_pkg::SCREEN_HEIGHT;
	localparam int RB = mfre_pkg::ROW_BYTES;
	localparam int AW = mfre_pkg::ADDR_W;

	logic [7:0] mem [mfre_pkg::STORE_BYTES];

	logic [2:0]         op_q;
	logic signed [11:0] x1_q, x2_q, y_q, y2_q;   // clipped bounds / sprite origin
	logic [63:0]        rows_q;
	logic [9:0]         raddr_q;
	logic signed [11:0] row_q;                   // current row
	logic [11:0]        col_q;                   // current byte column
	logic               half_q;                  // sprite: 0 left byte, 1 right byte
	logic [7:0]         rdata_q;
	logic [2:0]         sh_q;
	logic signed [11:0] xp8_q;

	// extended request fields
	logic signed [11:0] xl, yt, xr, yb;
	assign xl = 12'(x_left);
	assign yt = 12'(y_top);
	assign xr = 12'(x_right);
	assign yb = 12'(y_bottom);

	// clip span/rect bounds and sprite rows at load time
	logic signed [11:0] cx1, cx2, cy1, cy2, xp8;
	logic               empty_c;
	always_comb begin
		cx1 = (xl < 0) ? 12'sd0 : xl;
		cx2 = (xr > 12'(W - 1)) ? 12'(W - 1) : xr;
		cy1 = yt;
		cy2 = yt;
		xp8 = xl + 12'sd8;
		empty_c = 1'b0;
		unique case (opcode)
			mfre_pkg::OP_SPRITE: begin
				cy1 = (yt < 0) ? 12'sd0 : yt;
				cy2 = (yt > 12'(H - 8)) ? 12'(H - 1) : yt + 12'sd7;
				empty_c = (xl < -12'sd7) || (xl > 12'(W - 1)) ||
					(yt < -12'sd7) || (yt > 12'(H - 1));
			end
			mfre_pkg::OP_SPAN, mfre_pkg::OP_RECT: begin
				if (opcode == mfre_pkg::OP_RECT) begin
					cy1 = (yt < 0) ? 12'sd0 : yt;
					cy2 = (yb > 12'(H - 1)) ? 12'(H - 1) : yb;
				end
				empty_c = (cy1 < 0) || (cy2 > 12'(H - 1)) || (cy1 > cy2) ||
					(cy1 > 12'(H - 1)) || (cy2 < 0) ||
					(xl < 0 && xr < 0) ||
					(xl > 12'(W - 1) && xr > 12'(W - 1)) || (cx1 > cx2);
			end
			default: empty_c = 1'b1;
		endcase
	end

	// per-position mask and address; a clear walks the whole store
	logic signed [11:0] cur_col;
	logic [11:0]        c_hi;
	logic [7:0]         mask;
	logic [15:0]        wide;
	logic [7:0]         srow;
	logic [3:0]         ridx;
	logic               skip_c, last_c;
	logic [3:0]         lo, hi;
	always_comb begin
		c_hi = 12'(x2_q >>> 3);
		ridx = 4'(row_q - y_q);
		srow = rows_q[6'(56 - 8 * 32'(ridx)) +: 8];
		wide = {srow, 8'h00} >> sh_q;
		lo = 4'd0;
		hi = 4'd7;
		if (op_q == mfre_pkg::OP_SPRITE) begin
			cur_col = $signed(12'((xp8_q >>> 3) - 12'sd1)) + 12'(half_q);
			mask = half_q ? wide[7:0] : wide[15:8];
			skip_c = half_q ? ((sh_q == 3'd0) || (cur_col >= 12'(RB)))
				: (cur_col < 0);
			last_c = (row_q == y2_q) && half_q;
		end else begin
			cur_col = $signed(col_q);
			if (x1_q > $signed(col_q << 3)) lo = 4'(x1_q - $signed(col_q << 3));
			if (x2_q < $signed((col_q << 3) + 12'd7)) hi = 4'(x2_q - $signed(col_q << 3));
			mask = (8'hFF >> lo) & (8'hFF << (4'd7 - hi));
			skip_c = 1'b0;
			if (op_q == mfre_pkg::OP_CLEAR)
				last_c = (row_q == 12'(H - 1)) && (col_q == 12'(RB - 1));
			else
				last_c = (row_q == y2_q) && (col_q == c_hi);
		end
	end

	logic [AW-1:0] addr;
	assign addr = AW'(32'(row_q) * RB + 32'(cur_col));

	assign stat.empty = empty_c;
	assign stat.last  = last_c;
	assign stat.skip  = skip_c;

	// request capture and walk counters; reset starts the blanking walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= mfre_pkg::OP_CLEAR;
			row_q <= '0;
			col_q <= '0;
			half_q <= 1'b0;
		end else if (cmd.load) begin
			op_q   <= opcode;
			row_q  <= (opcode == mfre_pkg::OP_CLEAR) ? 12'sd0 : cy1;
			col_q  <= (opcode == mfre_pkg::OP_CLEAR) ? 12'd0 : 12'(cx1 >>> 3);
			half_q <= 1'b0;
		end else if (cmd.step) begin
			if (op_q == mfre_pkg::OP_CLEAR) begin
				if (col_q == 12'(RB - 1)) begin
					col_q <= '0;
					row_q <= row_q + 12'sd1;
				end else col_q <= col_q + 12'd1;
			end else if (op_q == mfre_pkg::OP_SPRITE) begin
				half_q <= ~half_q;
				if (half_q) row_q <= row_q + 12'sd1;
			end else if (col_q == c_hi) begin
				col_q <= 12'(x1_q >>> 3);
				row_q <= row_q + 12'sd1;
			end else col_q <= col_q + 12'd1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x1_q <= cx1;
			x2_q <= cx2;
			y_q  <= yt;
			y2_q <= (opcode == mfre_pkg::OP_CLEAR) ? 12'(H - 1) : cy2;
			xp8_q <= xp8;
			sh_q <= 3'(xp8);
			rows_q <= sprite_rows;
			raddr_q <= read_address;
		end
	end

	// frame store
	always_ff @(posedge clk) begin
		if (cmd.clr_wr) mem[addr] <= 8'h00;
		else if (cmd.wr) mem[addr] <= rdata_q | mask;
		if (cmd.rd) rdata_q <= mem[addr];
		else if (cmd.rd_out) rdata_q <= mem[AW'(raddr_q)];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_data <= '0;
			done_opcode <= '0;
		end else if (cmd.out_load) begin
			done_opcode <= op_q;
			read_data <= (op_q == mfre_pkg::OP_READ &&
				32'(raddr_q) < mfre_pkg::STORE_BYTES) ? rdata_q : 8'h00;
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/mfre_ctrl.sv
// Controller state machine: sequences clear, draw walks, reads and output.
// Depends on mfre_pkg.
`default_nettype none
module mfre_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_valid,
	output logic             s_ready,
	output logic             m_valid,
	input  wire              m_ready,
	input  wire  [2:0]       opcode,
	input  wire mfre_pkg::stat_t stat,
	output mfre_pkg::cmd_t   cmd
);
	mfre_pkg::state_t state_q, state_d;
	logic mv_q, mv_d;

	// hold state and output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfre_pkg::ST_INIT;
			mv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mv_q <= mv_d;
		end
	end

	assign m_valid = mv_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_ready = 1'b0;
		mv_d = mv_q && !m_ready;
		unique case (state_q)
			mfre_pkg::ST_INIT: begin
				// blank the store after reset, no result
				cmd.clr_wr = 1'b1;
				cmd.step = 1'b1;
				if (stat.last) state_d = mfre_pkg::ST_IDLE;
			end
			mfre_pkg::ST_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					cmd.load = 1'b1;
					unique case (opcode)
						mfre_pkg::OP_CLEAR: state_d = mfre_pkg::ST_CLEAR;
						mfre_pkg::OP_READ: state_d = mfre_pkg::ST_READ;
						default: state_d = stat.empty ? mfre_pkg::ST_OUT
							: mfre_pkg::ST_WALK;
					endcase
				end
			end
			mfre_pkg::ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				cmd.step = 1'b1;
				if (stat.last) state_d = mfre_pkg::ST_OUT;
			end
			mfre_pkg::ST_WALK: begin
				if (stat.skip) begin
					cmd.step = 1'b1;
					if (stat.last) state_d = mfre_pkg::ST_OUT;
				end else begin
					cmd.rd = 1'b1;
					state_d = mfre_pkg::ST_RMW;
				end
			end
			mfre_pkg::ST_RMW: begin
				cmd.wr = 1'b1;
				cmd.step = 1'b1;
				state_d = stat.last ? mfre_pkg::ST_OUT : mfre_pkg::ST_WALK;
			end
			mfre_pkg::ST_READ: begin
				cmd.rd_out = 1'b1;
				state_d = mfre_pkg::ST_OUT;
			end
			mfre_pkg::ST_OUT: begin
				if (!mv_q || m_ready) begin
					cmd.out_load = 1'b1;
					mv_d = 1'b1;
					state_d = mfre_pkg::ST_IDLE;
				end
			end
			default: state_d = mfre_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/core/mono_framebuffer_raster_engine_core.sv
// Request to result: a read reads the store and then loads the result; a clear
// writes zero to every store byte; a draw reads and writes back each touched byte
// through the single store port; nothing to draw goes straight to the result. Throughput:
// one request at a time; the next is taken the cycle after the result loads, even while
// that result waits. Reset: arst_n clears control, then a pass over the whole store blanks it with
// s_tready low. Controller plus datapath; depends on mfre_pkg, mfre_ctrl, mfre_datapath.
`default_nettype none
module mono_framebuffer_raster_engine_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// opcode[2:0], x_left[12:3], y_top[22:13], x_right[32:23], y_bottom[42:33],
	// sprite_rows[106:43], read_address[116:107], zero pad to 120
	input  wire [119:0] s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// read_data[7:0], done_opcode[10:8], zero pad to 16
	output logic [15:0] m_tdata
);
	mfre_pkg::cmd_t  cmd;
	mfre_pkg::stat_t stat;
	logic [7:0] rd;
	logic [2:0] dop;

	mfre_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_valid(s_tvalid), .s_ready(s_tready),
		.m_valid(m_tvalid), .m_ready(m_tready), .opcode(s_tdata[2:0]),
		.stat(stat), .cmd(cmd)
	);

	mfre_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.opcode(s_tdata[2:0]), .x_left(s_tdata[12:3]), .y_top(s_tdata[22:13]),
		.x_right(s_tdata[32:23]), .y_bottom(s_tdata[42:33]),
		.sprite_rows(s_tdata[106:43]), .read_address(s_tdata[116:107]),
		.read_data(rd), .done_opcode(dop)
	);

	assign m_tdata = {5'd0, dop, rd};
endmodule
`default_nettype wire

>>> rtl/core/mfre_checker.sv
// Port-level checker for the raster engine, bound to the top level.
// Depends on mfre_pkg and mono_framebuffer_raster_engine_core ports.
`default_nettype none
module mfre_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [15:0] m_tdata
);
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");
	// accepting a request never completes on the same edge
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready after accept");
	// non-read results carry zero data
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[10:8] != mfre_pkg::OP_READ |-> m_tdata[7:0] == 8'd0)
		else $error("nonzero data on non-read");
	// padding is zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:11] == 5'd0)
		else $error("pad bits set");
endmodule

bind mono_framebuffer_raster_engine_core mfre_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
